>>> rtl/stip_pkg.sv
// ----------------------------------------------------------------------------
// stip_pkg
// shared types and constants for the sorted table insert position block
// ----------------------------------------------------------------------------
package stip_pkg;

   // field widths of the item, result and count register ports
   localparam int COUNT_W = 11;
   localparam int INDEX_W = 10;
   localparam int VALUE_W = 32;
   localparam int POS_W   = 11;

   // default table size
   localparam int DEPTH_DEFAULT = 1024;

   // command codes
   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_SEARCH = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PROBE,
      ST_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic init;
      logic step;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic more;
   } dp_stat_type;

endpackage

>>> rtl/stip_ram.sv
// ----------------------------------------------------------------------------
// stip_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module stip_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/stip_ctrl.sv
// ----------------------------------------------------------------------------
// stip_ctrl
// sequencer for write and search items
// ----------------------------------------------------------------------------
module stip_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 command,
   input  stip_pkg::dp_stat_type stat,
   output logic                 busy,
   output logic                 wr_go,
   output logic                 rsp_strobe,
   output stip_pkg::dp_cmd_type dp_cmd
);

   import stip_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start && (command == CMD_SEARCH)) begin
               state_in = ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (!stat.more) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      busy        = 1'b1;
      wr_go       = 1'b0;
      rsp_strobe  = 1'b0;
      dp_cmd.init = 1'b0;
      dp_cmd.step = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            busy        = 1'b0;
            wr_go       = start && (command == CMD_WRITE);
            dp_cmd.init = start && (command == CMD_SEARCH);
         end
         ST_PROBE: begin
            dp_cmd.step = 1'b1;
         end
         ST_DONE: begin
            rsp_strobe = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

>>> rtl/stip_dp.sv
// ----------------------------------------------------------------------------
// stip_dp
// entry count register, search bounds, probe address and compare for the lower-bound search
// ----------------------------------------------------------------------------
module stip_dp #(
   parameter int TABLE_DEPTH = stip_pkg::DEPTH_DEFAULT,
   localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [stip_pkg::COUNT_W-1:0]  csr_write_data,
   input  stip_pkg::dp_cmd_type          dp_cmd,
   input  logic signed [stip_pkg::VALUE_W-1:0] target,
   input  logic [stip_pkg::VALUE_W-1:0]  rd_data,
   output logic [ADDR_W-1:0]             rd_addr,
   output stip_pkg::dp_stat_type         stat,
   output logic [stip_pkg::POS_W-1:0]    position,
   output logic                          found
);

   import stip_pkg::*;

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   logic [COUNT_W-1:0]        count_ff;
   logic [CNT_W-1:0]          lo_ff;
   logic [CNT_W-1:0]          hi_ff;
   logic [ADDR_W-1:0]         mid_ff;
   logic                      pend_ff;
   logic                      eq_ff;
   logic signed [VALUE_W-1:0] tgt_ff;

   logic [CNT_W-1:0] n_sat;
   logic [CNT_W-1:0] cur_lo;
   logic [CNT_W-1:0] cur_hi;
   logic             cur_eq;
   logic [CNT_W:0]   sum;
   logic [ADDR_W-1:0] mid_in;
   logic             more;
   logic             load;

   // count beyond the table saturates to the depth
   always_comb begin
      if (32'(count_ff) > 32'(TABLE_DEPTH)) begin
         n_sat = CNT_W'(TABLE_DEPTH);
      end else begin
         n_sat = CNT_W'(count_ff);
      end
   end

   always_comb begin
      cur_lo = lo_ff;
      cur_hi = hi_ff;
      cur_eq = eq_ff;
      if (dp_cmd.init) begin
         cur_lo = '0;
         cur_hi = n_sat;
         cur_eq = 1'b0;
      end else if (dp_cmd.step && pend_ff) begin
         // probe data for mid_ff is back from the ram
         if ($signed(rd_data) < tgt_ff) begin
            cur_lo = CNT_W'(mid_ff) + CNT_W'(1);
         end else begin
            cur_hi = CNT_W'(mid_ff);
            cur_eq = ($signed(rd_data) == tgt_ff);
         end
      end
      sum    = {1'b0, cur_lo} + {1'b0, cur_hi};
      mid_in = ADDR_W'(sum[CNT_W:1]);
      more   = (cur_lo < cur_hi);
   end

   assign load = dp_cmd.init || dp_cmd.step;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            count_ff <= csr_write_data;
         end
         if (load) begin
            pend_ff <= more;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         lo_ff  <= cur_lo;
         hi_ff  <= cur_hi;
         eq_ff  <= cur_eq;
         mid_ff <= mid_in;
      end
      if (dp_cmd.init) begin
         tgt_ff <= target;
      end
   end

   assign rd_addr   = mid_in;
   assign stat.more = more;
   assign position  = POS_W'(lo_ff);
   // eq_ff tracks the probe that last moved hi, which is the final position
   assign found     = eq_ff;

endmodule

>>> rtl/sorted_table_insert_position.sv
// ----------------------------------------------------------------------------
// sorted_table_insert_position
// lower-bound binary search over a table of signed 32-bit values
// ----------------------------------------------------------------------------
// a write item (command 0) stores entry_value at entry_index and gives no
// result; busy stays low, so writes may follow one per cycle. a search item
// (command 1) returns the index of the first entry not less than target (the
// entry count, capped at the table depth, if all are smaller) and a found
// flag when that entry equals target. a search keeps busy high after it is
// taken until its result is given, and makes at most floor(log2(n))+1 and
// at least floor(log2(n)) probes for n entries (0 probes when empty).
// rsp_strobe is high for one cycle, the last busy cycle, with the result on
// rsp_position/rsp_found. one probe per cycle is set by the loop from the
// table ram's registered read through the signed compare and the midpoint
// add back to the read address. the receiver cannot stall, so the result
// must be taken on the strobe. entries must be written before a search can
// probe them; the table has no reset.
// ----------------------------------------------------------------------------
module sorted_table_insert_position #(
   parameter int TABLE_DEPTH = stip_pkg::DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // item input
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_command,
   input  logic [stip_pkg::INDEX_W-1:0]        req_entry_index,
   input  logic signed [stip_pkg::VALUE_W-1:0] req_entry_value,
   input  logic signed [stip_pkg::VALUE_W-1:0] req_target,
   // result
   output logic                                rsp_strobe,
   output logic [stip_pkg::POS_W-1:0]          rsp_position,
   output logic                                rsp_found,
   // entry count register
   input  logic                                csr_write_enable,
   input  logic [stip_pkg::COUNT_W-1:0]        csr_write_data
);

   import stip_pkg::*;

   localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   dp_cmd_type          dp_cmd;
   dp_stat_type         dp_stat;
   logic                wr_go;
   logic                wr_en;
   logic [ADDR_W-1:0]   rd_addr;
   logic [VALUE_W-1:0]  rd_data;

   // sequencer
   stip_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .command    (req_command),
      .stat       (dp_stat),
      .busy       (busy),
      .wr_go      (wr_go),
      .rsp_strobe (rsp_strobe),
      .dp_cmd     (dp_cmd)
   );

   // bounds, midpoint and compare
   stip_dp #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .dp_cmd           (dp_cmd),
      .target           (req_target),
      .rd_data          (rd_data),
      .rd_addr          (rd_addr),
      .stat             (dp_stat),
      .position         (rsp_position),
      .found            (rsp_found)
   );

   // writes past the end of the table are dropped
   assign wr_en = wr_go && (32'(req_entry_index) < 32'(TABLE_DEPTH));

   // table storage, written only while idle; its read data is used only while searching
   stip_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (ADDR_W'(req_entry_index)),
      .wr_data (req_entry_value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule
